// File: sv/rrhl_pkg.sv
// ----------------------------------------------------------------------------
// rrhl_pkg
// shared types and fixed field widths of the rectangle hit lookup
// ----------------------------------------------------------------------------
package rrhl_pkg;

    localparam int INDEX_BITS  = 4;
    localparam int ACTIVE_BITS = 5;
    localparam int SLOT_BITS   = 4;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed
    {
        logic                 hit;
        logic [SLOT_BITS-1:0] hit_slot;
    } result_t;

endpackage

// File: sv/rrhl_table.sv
// ----------------------------------------------------------------------------
// rrhl_table
// rectangle table memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module rrhl_table #(
    parameter int DEPTH      = 16,
    parameter int ADDR_BITS  = 4,
    parameter int DATA_BITS  = 48
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rrhl_scan.sv
// ----------------------------------------------------------------------------
// rrhl_scan
// query sequencer: walks the table one entry per cycle, first-match compare
// ----------------------------------------------------------------------------
module rrhl_scan #(
    parameter int MAX_SPOTS  = 16,
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 4,
    parameter int CNT_BITS   = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rrhl_pkg::ACTIVE_BITS-1:0]    active_count,
    input  logic                                start,
    input  logic [COORD_BITS-1:0]               point_x,
    input  logic [COORD_BITS-1:0]               point_y,
    output logic                                ready,
    output logic                                rd_en,
    output logic [ADDR_BITS-1:0]                rd_addr,
    input  logic [4*COORD_BITS-1:0]             rd_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output rrhl_pkg::result_t                   res
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_EMPTY
    } state_t;

    state_t                state_reg;
    logic [ADDR_BITS-1:0]  idx_reg;
    logic [CNT_BITS-1:0]   limit_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic                  res_valid_reg;
    rrhl_pkg::result_t     res_reg;

    logic [COORD_BITS-1:0] ent_x;
    logic [COORD_BITS-1:0] ent_y;
    logic [COORD_BITS-1:0] ent_w;
    logic [COORD_BITS-1:0] ent_h;
    logic [COORD_BITS:0]   ent_right;
    logic [COORD_BITS:0]   ent_bottom;
    logic                  match;
    logic                  last;
    logic                  stall;
    logic                  res_load;
    logic [CNT_BITS-1:0]   limit_next;
    int                    limit_i;

    assign ent_x = rd_data[COORD_BITS-1:0];
    assign ent_y = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign ent_w = rd_data[3*COORD_BITS-1:2*COORD_BITS];
    assign ent_h = rd_data[4*COORD_BITS-1:3*COORD_BITS];

    assign ent_right  = {1'b0, ent_x} + {1'b0, ent_w};
    assign ent_bottom = {1'b0, ent_y} + {1'b0, ent_h};

    assign match = (px_reg >= ent_x) && ({1'b0, px_reg} < ent_right)
                && (py_reg >= ent_y) && ({1'b0, py_reg} < ent_bottom);

    assign last  = ((CNT_BITS'(idx_reg) + CNT_BITS'(1)) == limit_reg);
    assign stall = res_valid_reg && !res_ready;

    assign res_load = !stall
                   && (((state_reg == S_SCAN) && (match || last))
                       || (state_reg == S_EMPTY));

    always_comb
    begin
        if (int'(active_count) > MAX_SPOTS)
        begin
            limit_i = MAX_SPOTS;
        end
        else
        begin
            limit_i = int'(active_count);
        end
        limit_next = CNT_BITS'(limit_i);
    end

    // read port: first entry on start, next entry while the scan moves on
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = start;
                rd_addr = '0;
            end
            S_SCAN:
            begin
                rd_en   = !(match || last);
                rd_addr = idx_reg + ADDR_BITS'(1);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            limit_reg     <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        px_reg    <= point_x;
                        py_reg    <= point_y;
                        idx_reg   <= '0;
                        limit_reg <= limit_next;
                        if (limit_next == '0)
                        begin
                            state_reg <= S_EMPTY;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (match || last)
                    begin
                        if (!stall)
                        begin
                            res_reg.hit      <= match;
                            res_reg.hit_slot <= match
                                ? rrhl_pkg::SLOT_BITS'(idx_reg)
                                : '0;
                            state_reg        <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ADDR_BITS'(1);
                    end
                end
                S_EMPTY:
                begin
                    if (!stall)
                    begin
                        res_reg.hit      <= 1'b0;
                        res_reg.hit_slot <= '0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ready     = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // scan index stays inside the searched range
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_BITS'(idx_reg) < limit_reg))
        else $error("scan index beyond limit");

    // a miss always reports slot zero
    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.hit) |-> (res_reg.hit_slot == '0))
        else $error("miss with nonzero slot");

    // an accepted query leaves idle on the next cycle
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg != S_IDLE))
        else $error("query not started");

    // a new result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg && $stable(res_reg))
        else $error("pending result overwritten");

endmodule

// File: sv/rect_region_hit_lookup_core.sv
// ----------------------------------------------------------------------------
// rect_region_hit_lookup_core
// first-match point-in-rectangle lookup over a table of screen rectangles
// ----------------------------------------------------------------------------
// channel   dir  request
// s_axis    in   tuser=op, tdata=entry_index, rect x/y/w/h, point x/y
// m_axis    out  tdata=hit, hit_slot (queries only)
// cfg       in   cfg_wr_en/cfg_wr_data write active_count
//
// a write request lands in the table at its accept edge
// a query scans one entry per cycle through the table's single read port,
// stopping at the first hit or after limit entries, limit being
// min(active_count, MAX_SPOTS); a limit of 0 gives a miss without a scan
// s_tready is low while a query scans or waits on a full result register
// rst_n clears the config and scan registers, the table holds no reset value
// ----------------------------------------------------------------------------
module rect_region_hit_lookup_core #(
    parameter int MAX_SPOTS  = 16,
    parameter int COORD_BITS = 12,
    localparam int IN_BITS   = rrhl_pkg::INDEX_BITS + 6 * COORD_BITS,
    localparam int IN_WIDTH  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 1 + rrhl_pkg::SLOT_BITS,
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index, rect_x, rect_y, rect_w, rect_h, point_x, point_y, zero pad
    input  logic [IN_WIDTH-1:0]              s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit, hit_slot, zero pad
    output logic [OUT_WIDTH-1:0]             m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [rrhl_pkg::ACTIVE_BITS-1:0] cfg_wr_data
);

    localparam int ADDR_BITS = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_SPOTS + 1);
    localparam int IX        = rrhl_pkg::INDEX_BITS;

    logic [rrhl_pkg::ACTIVE_BITS-1:0]   active_count_reg;
    logic [rrhl_pkg::INDEX_BITS-1:0]    entry_index;
    logic [COORD_BITS-1:0]              rect_x;
    logic [COORD_BITS-1:0]              rect_y;
    logic [COORD_BITS-1:0]              rect_w;
    logic [COORD_BITS-1:0]              rect_h;
    logic [COORD_BITS-1:0]              point_x;
    logic [COORD_BITS-1:0]              point_y;
    logic                               accept;
    logic                               wr_en;
    logic                               query_start;
    logic                               scan_ready;
    logic                               rd_en;
    logic [ADDR_BITS-1:0]               rd_addr;
    logic [4*COORD_BITS-1:0]            rd_data;
    rrhl_pkg::result_t                  res;

    assign entry_index = s_tdata[IX-1:0];
    assign rect_x      = s_tdata[IX+1*COORD_BITS-1:IX+0*COORD_BITS];
    assign rect_y      = s_tdata[IX+2*COORD_BITS-1:IX+1*COORD_BITS];
    assign rect_w      = s_tdata[IX+3*COORD_BITS-1:IX+2*COORD_BITS];
    assign rect_h      = s_tdata[IX+4*COORD_BITS-1:IX+3*COORD_BITS];
    assign point_x     = s_tdata[IX+5*COORD_BITS-1:IX+4*COORD_BITS];
    assign point_y     = s_tdata[IX+6*COORD_BITS-1:IX+5*COORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            active_count_reg <= cfg_wr_data;
        end
    end

    assign s_tready    = scan_ready;
    assign accept      = s_tvalid && scan_ready;
    // slots beyond the table are dropped
    assign wr_en       = accept && (s_tuser == rrhl_pkg::OP_WRITE)
                      && (int'(entry_index) < MAX_SPOTS);
    assign query_start = accept && (s_tuser == rrhl_pkg::OP_QUERY);

    rrhl_table #(
        .DEPTH     (MAX_SPOTS),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (4 * COORD_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_BITS'(entry_index)),
        .wr_data ({rect_h, rect_w, rect_y, rect_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrhl_scan #(
        .MAX_SPOTS  (MAX_SPOTS),
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_count (active_count_reg),
        .start        (query_start),
        .point_x      (point_x),
        .point_y      (point_y),
        .ready        (scan_ready),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res          (res)
    );

    assign m_tdata = {{(OUT_WIDTH - OUT_BITS){1'b0}}, res.hit_slot, res.hit};

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rectangle hit lookup core
// requests are queued by a stimulus process, driven with random gaps and
// mirrored into a local model of the rectangle table; every returned hit and
// hit_slot is compared with the model's prediction for the oldest query
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_BITS  = 12;
    localparam int SPOTS       = 16;
    localparam int IN_WIDTH    =
        (((rrhl_pkg::INDEX_BITS + 6 * COORD_BITS) + 7) / 8) * 8;
    localparam int OUT_WIDTH   = (((1 + rrhl_pkg::SLOT_BITS) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_ITEMS = 105;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct
    {
        rrhl_pkg::op_t                   op;
        logic [rrhl_pkg::INDEX_BITS-1:0] idx;
        coord_t                          rx;
        coord_t                          ry;
        coord_t                          rw;
        coord_t                          rh;
        coord_t                          px;
        coord_t                          py;
    } req_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [IN_WIDTH-1:0]              s_tdata     = '0;
    logic                             s_tuser     = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [OUT_WIDTH-1:0]             m_tdata;
    logic                             cfg_wr_en   = 1'b0;
    logic [rrhl_pkg::ACTIVE_BITS-1:0] cfg_wr_data = '0;

    req_t                   req_queue[$];
    rrhl_pkg::result_t      hit_queue[$];
    req_t                   cur_req;
    rrhl_pkg::result_t      want;

    // table contents as seen by accepted requests
    coord_t                 spot_x[SPOTS];
    coord_t                 spot_y[SPOTS];
    coord_t                 spot_w[SPOTS];
    coord_t                 spot_h[SPOTS];
    // table contents as of the last generated request
    coord_t                 gen_x[SPOTS];
    coord_t                 gen_y[SPOTS];
    coord_t                 gen_w[SPOTS];
    coord_t                 gen_h[SPOTS];

    logic [rrhl_pkg::ACTIVE_BITS-1:0] count_model = '0;
    int                     err_count   = 0;
    int                     cycle_count = 0;
    logic                   no_idle     = 1'b0;
    logic                   stall_req   = 1'b0;
    logic                   stall_done;
    int                     hold_left;

    rect_region_hit_lookup_core #(
        .MAX_SPOTS  (SPOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic rrhl_pkg::result_t lookup_point(input coord_t px, input coord_t py);
        rrhl_pkg::result_t       res;
        int                      limit;
        logic [COORD_BITS:0]     right;
        logic [COORD_BITS:0]     bottom;
        res   = '0;
        limit = (count_model > SPOTS) ? SPOTS : int'(count_model);
        for (int i = 0; i < limit; i++)
        begin
            right  = {1'b0, spot_x[i]} + {1'b0, spot_w[i]};
            bottom = {1'b0, spot_y[i]} + {1'b0, spot_h[i]};
            if (px >= spot_x[i] && {1'b0, px} < right &&
                py >= spot_y[i] && {1'b0, py} < bottom)
            begin
                res.hit      = 1'b1;
                res.hit_slot = rrhl_pkg::SLOT_BITS'(i);
                break;
            end
        end
        return res;
    endfunction

    function automatic req_t fixed_write(input int slot, input int x, input int y,
                                         input int w, input int h);
        req_t r;
        r.op  = rrhl_pkg::OP_WRITE;
        r.idx = rrhl_pkg::INDEX_BITS'(slot);
        r.rx  = coord_t'(x);
        r.ry  = coord_t'(y);
        r.rw  = coord_t'(w);
        r.rh  = coord_t'(h);
        r.px  = coord_t'($urandom_range(4095));
        r.py  = coord_t'($urandom_range(4095));
        gen_x[slot] = r.rx;
        gen_y[slot] = r.ry;
        gen_w[slot] = r.rw;
        gen_h[slot] = r.rh;
        return r;
    endfunction

    function automatic req_t fixed_query(input int x, input int y);
        req_t r;
        r.op  = rrhl_pkg::OP_QUERY;
        r.idx = rrhl_pkg::INDEX_BITS'($urandom_range(15));
        r.rx  = coord_t'($urandom_range(4095));
        r.ry  = coord_t'($urandom_range(4095));
        r.rw  = coord_t'($urandom_range(4095));
        r.rh  = coord_t'($urandom_range(4095));
        r.px  = coord_t'(x);
        r.py  = coord_t'(y);
        return r;
    endfunction

    function automatic req_t random_write();
        int x;
        int y;
        int w;
        int h;
        x = $urandom_range(4095);
        y = $urandom_range(4095);
        case ($urandom_range(3))
            0:
            begin
                w = $urandom_range(4095);
                h = $urandom_range(4095);
            end
            3:
            begin
                x = 4095 - $urandom_range(3);
                y = 4095 - $urandom_range(3);
                w = 4095 - $urandom_range(3);
                h = 4095 - $urandom_range(3);
            end
            default:
            begin
                w = $urandom_range(400);
                h = $urandom_range(400);
            end
        endcase
        return fixed_write($urandom_range(15), x, y, w, h);
    endfunction

    function automatic req_t random_query();
        int s;
        int x;
        int y;
        int ix;
        int iy;
        s  = $urandom_range(15);
        ix = gen_x[s] + ((gen_w[s] != 0) ? $urandom_range(gen_w[s] - 1) : 0);
        iy = gen_y[s] + ((gen_h[s] != 0) ? $urandom_range(gen_h[s] - 1) : 0);
        case ($urandom_range(5))
            0:
            begin
                x = ix;
                y = iy;
            end
            1:
            begin
                x = gen_x[s] + gen_w[s] - $urandom_range(1);
                y = iy;
            end
            2:
            begin
                x = ix;
                y = gen_y[s] + gen_h[s] - $urandom_range(1);
            end
            3:
            begin
                x = gen_x[s] - $urandom_range(1);
                y = gen_y[s] - $urandom_range(1);
            end
            default:
            begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
            end
        endcase
        return fixed_query(x, y);
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (req_queue.size() != 0 || s_tvalid || hit_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_active_count(input int value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rrhl_pkg::ACTIVE_BITS'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_model  = rrhl_pkg::ACTIVE_BITS'(value);
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur_req.op == rrhl_pkg::OP_WRITE)
                begin
                    spot_x[cur_req.idx] = cur_req.rx;
                    spot_y[cur_req.idx] = cur_req.ry;
                    spot_w[cur_req.idx] = cur_req.rw;
                    spot_h[cur_req.idx] = cur_req.rh;
                end
                else
                begin
                    hit_queue.push_back(lookup_point(cur_req.px, cur_req.py));
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_queue.size() != 0 && (no_idle || $urandom_range(99) >= 19))
                begin
                    cur_req   = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.op;
                    s_tdata  <= {4'b0, cur_req.py, cur_req.px, cur_req.rh, cur_req.rw,
                                 cur_req.ry, cur_req.rx, cur_req.idx};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result ready, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            stall_done <= 1'b0;
        end
        else if (stall_req && !stall_done)
        begin
            stall_done <= 1'b1;
            hold_left  <= 400;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hit_queue.size() == 0)
            begin
                report_mismatch("result with no query pending");
            end
            else
            begin
                want = hit_queue.pop_front();
                if (m_tdata[0] !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", m_tdata[0], want.hit));
                if (m_tdata[rrhl_pkg::SLOT_BITS:1] !== want.hit_slot)
                    report_mismatch($sformatf("hit_slot %0d, expected %0d",
                                              m_tdata[rrhl_pkg::SLOT_BITS:1],
                                              want.hit_slot));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int phase_count[NUM_PHASES];
        phase_count = '{16, 1, 31, 0, 7, 17, 16, 2, 24, 16, 15};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty search before any entry exists
        req_queue.push_back(fixed_query(0, 0));
        req_queue.push_back(fixed_query(4095, 4095));
        // load every slot, edge cases first
        req_queue.push_back(fixed_write(0, 0, 0, 1, 1));
        req_queue.push_back(fixed_write(1, 4095, 4095, 4095, 4095));
        req_queue.push_back(fixed_write(2, 100, 200, 0, 50));
        req_queue.push_back(fixed_write(3, 100, 200, 10, 10));
        for (int i = 4; i < 15; i++)
            req_queue.push_back(fixed_write(i, 2000 + 20 * i, 3000, 5, 5));
        req_queue.push_back(fixed_write(15, 0, 0, 4095, 4095));

        set_active_count(16);
        req_queue.push_back(fixed_query(0, 0));
        req_queue.push_back(fixed_query(4095, 4095));
        req_queue.push_back(fixed_query(4094, 4094));
        req_queue.push_back(fixed_query(100, 200));
        req_queue.push_back(fixed_query(109, 209));
        req_queue.push_back(fixed_query(110, 205));
        req_queue.push_back(fixed_query(105, 210));
        req_queue.push_back(fixed_query(4095, 0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_active_count(phase_count[p]);
            no_idle = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 25)
                    req_queue.push_back(random_write());
                else
                    req_queue.push_back(random_query());
            end
            if (p == 2)
                stall_req = 1'b1;
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
sv/rrhl_pkg.sv
sv/rrhl_table.sv
sv/rrhl_scan.sv
sv/rect_region_hit_lookup_core.sv
tb/sv/tb.sv
